// ----- sv/swm_pkg.sv -----
package swm_pkg;

    localparam int CFG_WIDTH = 11;
    localparam int IDX_WIDTH = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_POP,
        S_PUSH,
        S_READ,
        S_OUT
    } t_back_state;

endpackage

// ----- sv/swm_front.sv -----
module swm_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_restart,
    output logic                    o_q_valid,
    input  logic                    i_q_pop,
    output logic [SAMPLE_WIDTH-1:0] o_q_key,
    output logic                    o_q_restart
);

    logic [SAMPLE_WIDTH-1:0] r_q_key [2];
    logic                    r_q_rst [2];
    logic                    r_wr_ptr, n_wr_ptr;
    logic                    r_rd_ptr, n_rd_ptr;
    logic [1:0]              r_fill, n_fill;
    logic                    push;

    // order-preserving key: sign bit flipped, compared unsigned downstream
    localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    assign o_in_stall  = (r_fill == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_q_valid   = (r_fill != 2'd0);
    assign o_q_key     = r_q_key[r_rd_ptr];
    assign o_q_restart = r_q_rst[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? !r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !i_q_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!push && i_q_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_key[r_wr_ptr] <= i_sample ^ SIGN_BIT;
            r_q_rst[r_wr_ptr] <= i_restart;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_fill != 2'd0))
        else $error("queue popped while empty");
`endif

endmodule

// ----- sv/swm_back.sv -----
module swm_back
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_WIDTH-1:0]    i_cfg_wdata,
    input  logic                    i_q_valid,
    output logic                    o_q_pop,
    input  logic [SAMPLE_WIDTH-1:0] i_q_key,
    input  logic                    i_q_restart,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_WIDTH-1:0] o_window_max,
    output logic [IDX_WIDTH-1:0]    o_sample_index
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = SAMPLE_WIDTH + IDX_WIDTH;
    localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [IDX_WIDTH-1:0]    MAXW_IDX = IDX_WIDTH'(MAX_WINDOW);

    t_back_state r_state, n_state;

    logic [AW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_count, n_count;
    logic [IDX_WIDTH-1:0]    r_seen, n_seen;
    logic                    r_full, n_full;
    logic [CFG_WIDTH-1:0]    r_wlen, n_wlen;
    logic                    r_ov, n_ov;
    logic [SAMPLE_WIDTH-1:0] r_key, n_key;
    logic [IDX_WIDTH-1:0]    r_idx, n_idx;
    logic [SAMPLE_WIDTH-1:0] r_outval, n_outval;
    logic [SAMPLE_WIDTH-1:0] r_omax, n_omax;
    logic [IDX_WIDTH-1:0]    r_oidx, n_oidx;

    logic [EW-1:0]           r_mem [MAX_WINDOW];
    logic [EW-1:0]           r_rd_data;
    logic                    mem_re, mem_we;
    logic [AW-1:0]           mem_ra, mem_wa;

    logic [SAMPLE_WIDTH-1:0] rd_key;
    logic [IDX_WIDTH-1:0]    rd_pos;
    logic [IDX_WIDTH-1:0]    win;
    logic                    hd_drop;
    logic [CW-1:0]           cnt_after_head;
    logic                    tail_keeps;
    logic                    ring_full;
    logic [CW-1:0]           push_c;
    logic [AW-1:0]           push_h;
    logic                    full_next;
    logic [CW-1:0]           idle_cnt;
    logic                    out_load;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] h);
        logic [AW-1:0] r;
        if (h == AW'(MAX_WINDOW - 1)) begin
            r = '0;
        end else begin
            r = AW'(h + AW'(1));
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(off);
        if (s >= (CW+1)'(MAX_WINDOW)) begin
            s = (CW+1)'(s - (CW+1)'(MAX_WINDOW));
        end
        return s[AW-1:0];
    endfunction

    assign rd_key = r_rd_data[EW-1:IDX_WIDTH];
    assign rd_pos = r_rd_data[IDX_WIDTH-1:0];

    always_comb begin
        if (r_wlen == '0) begin
            win = IDX_WIDTH'(1);
        end else if (IDX_WIDTH'(r_wlen) > MAXW_IDX) begin
            win = MAXW_IDX;
        end else begin
            win = IDX_WIDTH'(r_wlen);
        end
    end

    assign hd_drop        = (IDX_WIDTH'(r_idx - rd_pos) >= win);
    assign cnt_after_head = hd_drop ? CW'(r_count - CW'(1)) : r_count;
    assign tail_keeps     = (rd_key > r_key);
    assign ring_full      = (r_count >= CW'(MAX_WINDOW));
    assign push_c         = ring_full ? CW'(r_count - CW'(1)) : r_count;
    assign push_h         = ring_full ? inc_ptr(r_head) : r_head;
    assign full_next      = r_full || (r_idx >= IDX_WIDTH'(win - IDX_WIDTH'(1)));
    assign idle_cnt       = i_q_restart ? '0 : r_count;
    assign out_load       = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (idle_cnt != '0) ? S_HEAD : S_PUSH;
                end
            end
            S_HEAD: n_state = (cnt_after_head != '0) ? S_POP : S_PUSH;
            S_POP: begin
                if (tail_keeps || r_count == CW'(1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!full_next) begin
                    n_state = S_IDLE;
                end else if (push_c == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_seen   = r_seen;
        n_full   = r_full;
        n_wlen   = r_wlen;
        n_key    = r_key;
        n_idx    = r_idx;
        n_outval = r_outval;
        n_omax   = r_omax;
        n_oidx   = r_oidx;
        n_ov     = r_ov && i_out_stall;
        o_q_pop  = 1'b0;
        mem_re   = 1'b0;
        mem_ra   = r_head;
        mem_we   = 1'b0;
        mem_wa   = slot_of(push_h, push_c);
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_key   = i_q_key;
                    if (i_q_restart) begin
                        n_head  = '0;
                        n_count = '0;
                        n_full  = 1'b0;
                        n_idx   = '0;
                    end else begin
                        n_idx   = r_seen;
                    end
                    mem_re = (idle_cnt != '0);
                    mem_ra = r_head;
                end
            end
            S_HEAD: begin
                if (hd_drop) begin
                    n_head  = inc_ptr(r_head);
                    n_count = cnt_after_head;
                end
                mem_re = (cnt_after_head != '0);
                mem_ra = slot_of(hd_drop ? inc_ptr(r_head) : r_head,
                                 CW'(cnt_after_head - CW'(1)));
            end
            S_POP: begin
                if (!tail_keeps) begin
                    n_count = CW'(r_count - CW'(1));
                    mem_re  = (r_count != CW'(1));
                    mem_ra  = slot_of(r_head, CW'(r_count - CW'(2)));
                end
            end
            S_PUSH: begin
                mem_we  = 1'b1;
                n_head  = push_h;
                n_count = CW'(push_c + CW'(1));
                n_seen  = IDX_WIDTH'(r_idx + IDX_WIDTH'(1));
                n_full  = full_next;
                n_outval = r_key;
                mem_re  = full_next && (push_c != '0);
                mem_ra  = push_h;
            end
            S_READ: n_outval = rd_key;
            S_OUT: begin
                if (out_load) begin
                    n_ov   = 1'b1;
                    n_omax = r_outval ^ SIGN_BIT;
                    n_oidx = r_idx;
                end
            end
            default: ;
        endcase
        // a write of the window length restarts the series
        if (i_cfg_we) begin
            n_wlen  = i_cfg_wdata;
            n_head  = '0;
            n_count = '0;
            n_seen  = '0;
            n_full  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_seen  <= '0;
            r_full  <= 1'b0;
            r_wlen  <= CFG_WIDTH'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_full  <= n_full;
            r_wlen  <= n_wlen;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_outval <= n_outval;
        r_omax   <= n_omax;
        r_oidx   <= n_oidx;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= {r_key, r_idx};
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    assign o_out_valid    = r_ov;
    assign o_window_max   = r_omax;
    assign o_sample_index = r_oidx;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WINDOW))
        else $error("deque count exceeds ring depth");
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && !i_cfg_we) |=> (r_count != '0))
        else $error("deque empty after push");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_ov && r_state == S_IDLE))
        else $error("result transfer not presented");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE && i_q_valid))
        else $error("queue popped outside idle");
`endif

endmodule

// ----- sv/sliding_window_maximum.sv -----
// Sliding window maximum over a stream of signed samples.
// Input channel: i_in_valid / o_in_stall carry i_sample and i_restart; a
// transfer happens on a clock edge with valid high and stall low. i_restart
// clears the window and the sample counter before the sample is taken.
// Output channel: o_out_valid / i_out_stall carry o_window_max and
// o_sample_index. No result is given until window_length samples have been
// seen since the last restart; after that every sample gives one result.
// Configuration: i_cfg_we writes i_cfg_wdata as window_length (0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW) and restarts the series.
// Write it only while the block is idle.
// Items are processed one at a time by the deque engine, which sequences a
// ring memory with one read and one write port: a warm-up sample that meets
// an empty deque passes through S_IDLE and S_PUSH only; otherwise the engine
// steps through S_IDLE, S_HEAD, S_POP while entries are popped from the tail,
// and S_PUSH, then, once the window is full, S_READ where needed and S_OUT.
// A two-entry input queue accepts samples while the engine is busy.
// Reset (synchronous, active low) empties the deque and queue, sets
// window_length to 1 and needs no clearing pass. While i_out_stall is high
// the result holds; the engine waits with the next result and the input
// queue fills, then raises o_in_stall.
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_WIDTH-1:0]    i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_restart,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_WIDTH-1:0] o_window_max,
    output logic [IDX_WIDTH-1:0]    o_sample_index
);

    logic                    q_valid;
    logic                    q_pop;
    logic [SAMPLE_WIDTH-1:0] q_key;
    logic                    q_restart;

    swm_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_restart  (i_restart),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_key    (q_key),
        .o_q_restart(q_restart)
    );

    swm_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_key       (q_key),
        .i_q_restart   (q_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_window_max  (o_window_max),
        .o_sample_index(o_sample_index)
    );

endmodule
